### hw/rtl/weighted_recursive_smoother_core_assert.svh
// Assertion macros shared by the smoother checker.
`ifndef WEIGHTED_RECURSIVE_SMOOTHER_CORE_ASSERT_SVH
`define WEIGHTED_RECURSIVE_SMOOTHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("smoother assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("smoother assertion failed");

`endif

### hw/rtl/wrs_pkg.sv
// Shared types and constants of the weighted recursive smoother.
package wrs_pkg;

  localparam int DataW   = 32;
  localparam int WeightW = 16;
  localparam int DiffW   = WeightW + 1;
  localparam int ProdW   = DataW + DiffW;
  localparam int SumW    = ProdW + 1;
  localparam int MagW    = 48;
  localparam int QuotW   = DataW;
  localparam int DivSteps = QuotW;
  localparam int CntW    = $clog2(DivSteps);

  localparam logic [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic check;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic seed;
  } stat_t;

endpackage

### hw/rtl/wrs_datapath.sv
// Datapath: products, sum, magnitude, radix-2 divider and saturation.
module wrs_datapath import wrs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output stat_t                     stat_o,
  input  logic signed [DataW-1:0]   sample_i,
  input  logic [WeightW-1:0]        weight_num_i,
  input  logic [WeightW-1:0]        weight_den_i,
  input  logic                      start_of_series_i,
  output logic signed [DataW-1:0]   smoothed_o,
  output logic                      saturated_o
);

  logic signed [DataW-1:0] x_q;
  logic [WeightW-1:0]      m_q;
  logic [WeightW-1:0]      n_q;
  logic                    seed_q;
  logic signed [DataW-1:0] y_q, y_d;
  logic signed [ProdW-1:0] p1_q, p2_q;
  logic signed [SumW-1:0]  num_q;
  logic                    neg_q;
  logic                    big_q;
  logic [WeightW-1:0]      rem_q;
  logic [QuotW-1:0]        work_q;
  logic [DataW-1:0]        res_q;
  logic                    sat_q;

  logic signed [DiffW-1:0] diff;
  logic [SumW-1:0]         mag_full;
  logic [MagW-1:0]         mag;
  logic [WeightW:0]        trial;
  logic                    ge;
  logic [WeightW:0]        trial_sub;
  logic [DataW-1:0]        res_d;
  logic                    sat_d;

  assign diff      = $signed({1'b0, n_q}) - $signed({1'b0, m_q});
  assign mag_full  = num_q[SumW-1] ? SumW'(-num_q) : SumW'(num_q);
  assign mag       = mag_full[MagW-1:0];
  assign trial     = {rem_q, work_q[QuotW-1]};
  assign ge        = trial >= {1'b0, n_q};
  assign trial_sub = trial - {1'b0, n_q};

  always_comb begin
    res_d = work_q;
    sat_d = 1'b0;
    if (seed_q) begin
      res_d = x_q;
    end else if (big_q) begin
      sat_d = 1'b1;
      res_d = neg_q ? SatMin : SatMax;
    end else if (neg_q) begin
      if (work_q > SatMin) begin
        sat_d = 1'b1;
        res_d = SatMin;
      end else begin
        res_d = DataW'(~work_q + 1'b1);
      end
    end else if (work_q[QuotW-1]) begin
      sat_d = 1'b1;
      res_d = SatMax;
    end
  end

  assign y_d = cmd_i.finish ? $signed(res_d) : y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q <= '0;
    end else begin
      y_q <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= sample_i;
      m_q    <= weight_num_i;
      n_q    <= (weight_den_i == '0) ? WeightW'(1) : weight_den_i;
      seed_q <= start_of_series_i;
    end
    if (cmd_i.mul) begin
      p1_q <= x_q * $signed({1'b0, m_q});
      p2_q <= y_q * diff;
    end
    if (cmd_i.sum) begin
      num_q <= {p1_q[ProdW-1], p1_q} + {p2_q[ProdW-1], p2_q};
    end
    if (cmd_i.check) begin
      neg_q  <= num_q[SumW-1];
      big_q  <= mag[MagW-1:QuotW] >= n_q;
      rem_q  <= mag[MagW-1:QuotW];
      work_q <= mag[QuotW-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? trial_sub[WeightW-1:0] : trial[WeightW-1:0];
      work_q <= {work_q[QuotW-2:0], ge};
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign stat_o.seed = seed_q;
  assign smoothed_o  = $signed(res_q);
  assign saturated_o = sat_q;

endmodule

### hw/rtl/wrs_ctrl.sv
// Controller: sequences one request through the datapath and holds the result handshake.
module wrs_ctrl import wrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            cnt_last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_last = cnt_q == CntW'(DivSteps - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = stat_i.seed ? ST_FIN : ST_SUM;
      ST_SUM:   state_d = ST_CHECK;
      ST_CHECK: state_d = ST_DIV;
      ST_DIV:   if (cnt_last) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    cnt_d      = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MUL: begin
        cmd_o.mul = !stat_i.seed;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        cnt_d       = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.finish ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/weighted_recursive_smoother_core.sv
// Top level of the weighted recursive smoother.
// Each request carries a signed Q16.16 sample with a weight m and a denominator n and
// updates the running value y to (x*m + y*(n-m)) / n, truncated toward zero and saturated
// to 32 bits; n of zero acts as one, and a request that starts a series loads y with its
// sample. One request is worked on at a time. A request that starts a series is accepted
// and then writes its result without products, sum, check or division; any other is
// accepted, forms the two products, the sum and the magnitude and overflow check, runs
// the radix-2 divider that produces one quotient bit per cycle, and writes the result. The
// result sits in an output register, so a new request is accepted while it waits; the block
// only holds in its final cycle while that register is still occupied.
module weighted_recursive_smoother_core import wrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] sample_i,
  input  logic [WeightW-1:0]      weight_num_i,
  input  logic [WeightW-1:0]      weight_den_i,
  input  logic                    start_of_series_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] smoothed_o,
  output logic                    saturated_o
);

  cmd_t  cmd;
  stat_t stat;

  wrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wrs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .sample_i          (sample_i),
    .weight_num_i      (weight_num_i),
    .weight_den_i      (weight_den_i),
    .start_of_series_i (start_of_series_i),
    .smoothed_o        (smoothed_o),
    .saturated_o       (saturated_o)
  );

endmodule

### hw/rtl/wrs_checker.sv
// Port-level checker for the weighted recursive smoother, bound to the top level.
`include "weighted_recursive_smoother_core_assert.svh"

module wrs_checker import wrs_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [DataW-1:0] smoothed_o,
  input logic                    saturated_o
);

  `WRS_ASSERT_NXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `WRS_ASSERT_NXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(smoothed_o) && $stable(saturated_o))
  `WRS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `WRS_ASSERT_IMP(a_sat_at_limit, clk_i, rst_ni, out_valid_o && saturated_o, smoothed_o == $signed(SatMax) || smoothed_o == $signed(SatMin))

endmodule

bind weighted_recursive_smoother_core wrs_checker u_wrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .smoothed_o  (smoothed_o),
  .saturated_o (saturated_o)
);

### tb/tb_weighted_recursive_smoother_core.sv
// Self-checking testbench for the weighted recursive smoother core.
module tb_weighted_recursive_smoother_core;
  import wrs_pkg::*;

  localparam int TotalItems = 700;
  localparam int SeriesMax = 12;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic signed [DataW-1:0] smoothed;
    logic saturated;
  } smoothed_result_t;

  class smoother_scoreboard;
    logic signed [DataW-1:0] running_value;
    smoothed_result_t expected_q[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned results;
    int unsigned series_starts;
    int unsigned clipped;

    function new();
      running_value = '0;
      mismatches = 0;
      requests = 0;
      results = 0;
      series_starts = 0;
      clipped = 0;
    endfunction

    function void note_request(logic signed [DataW-1:0] x, logic [WeightW-1:0] m,
                               logic [WeightW-1:0] n, logic start);
      longint xs;
      longint ys;
      longint ms;
      longint ns;
      longint num;
      longint quo;
      smoothed_result_t exp_res;
      xs = x;
      ys = running_value;
      ms = m;
      ns = n;
      if (ns < 1) ns = 1;
      exp_res.saturated = 1'b0;
      if (start) begin
        running_value = x;
        series_starts++;
      end else begin
        num = xs * ms + ys * (ns - ms);
        quo = num / ns;
        if (quo > longint'(SatMax) && quo > 0) begin
          running_value = SatMax;
          exp_res.saturated = 1'b1;
        end else if (quo < longint'($signed(SatMin))) begin
          running_value = SatMin;
          exp_res.saturated = 1'b1;
        end else begin
          running_value = quo[DataW-1:0];
        end
      end
      if (exp_res.saturated) clipped++;
      exp_res.smoothed = running_value;
      expected_q.push_back(exp_res);
      requests++;
    endfunction

    function void check_result(logic signed [DataW-1:0] y, logic sat);
      smoothed_result_t exp_res;
      results++;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: smoothed %0d saturated %0b",
                 $time, y, sat);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (y !== exp_res.smoothed) begin
        $display("%0t: smoothed expected %0d actual %0d", $time, exp_res.smoothed, y);
        mismatches++;
      end
      if (sat !== exp_res.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time, exp_res.saturated, sat);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DataW-1:0] sample_i = '0;
  logic [WeightW-1:0] weight_num_i = '0;
  logic [WeightW-1:0] weight_den_i = '0;
  logic start_of_series_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DataW-1:0] smoothed_o;
  logic saturated_o;

  smoother_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent = 0;
  int unsigned quiet_cycles = 0;

  weighted_recursive_smoother_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sample_i(sample_i),
    .weight_num_i(weight_num_i),
    .weight_den_i(weight_den_i),
    .start_of_series_i(start_of_series_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .smoothed_o(smoothed_o),
    .saturated_o(saturated_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(smoothed_o, saturated_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: no request or result moved for %0d cycles", $time, WatchdogLimit);
        $display("[weighted_recursive_smoother_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic signed [DataW-1:0] x, input logic [WeightW-1:0] m,
                              input logic [WeightW-1:0] n, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= x;
    weight_num_i <= m;
    weight_den_i <= n;
    start_of_series_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(x, m, n, start);
    sent++;
  endtask

  function automatic logic signed [DataW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return SatMax;
      1: return SatMin;
      2, 3: return int'($urandom_range(2097151)) - 1048576;
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_weights(output logic [WeightW-1:0] m, output logic [WeightW-1:0] n);
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 45) begin
      n = WeightW'($urandom_range(1, 16));
      m = WeightW'($urandom_range(0, n));
    end else if (kind < 70) begin
      n = WeightW'($urandom_range(1, 65535));
      m = WeightW'($urandom_range(0, n));
    end else if (kind < 80) begin
      n = '0;
      m = WeightW'($urandom_range(0, 1));
    end else begin
      n = WeightW'($urandom);
      m = WeightW'($urandom);
    end
  endtask

  initial begin
    logic [WeightW-1:0] m;
    logic [WeightW-1:0] n;
    int unsigned len;
    int unsigned phase;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Without a series start the update works from the reset value.
    send_request(32'sh0001_0000, 16'd1, 16'd2, 1'b0);
    send_request(32'sh0003_0000, 16'd0, 16'd0, 1'b0);
    send_request(SatMax, 16'd0, 16'd0, 1'b1);
    send_request(SatMax, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(SatMin, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(-32'sd1, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(32'sd0, 16'd0, 16'd0, 1'b1);
    send_request(-32'sd3, 16'd1, 16'd2, 1'b0);
    send_request(32'sd5, 16'd1, 16'd2, 1'b0);
    send_request(SatMin, 16'd7, 16'd3, 1'b1);
    send_request(SatMax, 16'hFFFF, 16'd1, 1'b0);
    send_request(SatMax, 16'd0, 16'd0, 1'b1);
    send_request(SatMin, 16'hFFFF, 16'd1, 1'b0);
    send_request(32'sd100, 16'd0, 16'd0, 1'b1);
    send_request(32'sd200, 16'd3, 16'd2, 1'b0);
    send_request(-32'sd12345, 16'd0, 16'hFFFF, 1'b0);
    send_request(32'sh7654_3210, 16'd1, 16'd1, 1'b0);
    send_request(32'sh1234_5678, 16'hFFFF, 16'd0, 1'b0);
    send_request(-32'sh0000_8000, 16'h8000, 16'h7FFF, 1'b0);

    while (sent < TotalItems) begin
      phase = sent * 4 / TotalItems;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if ($urandom_range(99) >= 8) begin
        pick_weights(m, n);
        send_request(pick_sample(), m, n, 1'b1);
      end
      len = $urandom_range(1, SeriesMax);
      repeat (len) begin
        pick_weights(m, n);
        send_request(pick_sample(), m, n, 1'b0);
      end
    end
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests (%0d series starts), checked %0d results, %0d clipped,",
             sb.requests, sb.series_starts, sb.results, sb.clipped);
    $display("over phases with no idling, sender gaps, receiver stalls and both.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[weighted_recursive_smoother_core] OK");
    end else begin
      $display("[weighted_recursive_smoother_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/wrs_pkg.sv
hw/rtl/wrs_datapath.sv
hw/rtl/wrs_ctrl.sv
hw/rtl/weighted_recursive_smoother_core.sv
hw/rtl/wrs_checker.sv
tb/tb_weighted_recursive_smoother_core.sv
